// ===== hdl/cpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpmd_pkg
// Types, constants and per-stage arithmetic for the complex polar
// multiply/divide pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cpmd_pkg;

  localparam int unsigned IN_WIDTH         = 16;
  localparam int unsigned DEF_CORDIC_STEPS = 16;
  localparam int unsigned IN_SHIFT         = (IN_WIDTH >= 32) ? 0 : 32 - IN_WIDTH;

  localparam int unsigned XW  = 36;
  localparam int unsigned AW  = 32;
  localparam int unsigned MW  = 33;
  localparam int unsigned DW  = MW + 24;
  localparam int unsigned PMW = 2 * MW - 32;
  localparam int unsigned DGW = 60;
  localparam int unsigned RW  = 60;
  localparam int unsigned ZW  = 34;
  localparam int unsigned QW  = 32;

  localparam logic [29:0]   INV_GAIN     = 30'd652032874;
  localparam logic [AW-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [AW-1:0] HALF_TURN    = 32'h8000_0000;

  localparam logic signed [RW:0] Q_MAX = (RW+1)'(64'sh7FFF_FFFF);
  localparam logic signed [RW:0] Q_MIN = (RW+1)'(-64'sh8000_0000);

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] a_real;
    logic signed [IN_WIDTH-1:0] a_imag;
    logic signed [IN_WIDTH-1:0] b_real;
    logic signed [IN_WIDTH-1:0] b_imag;
  } cpmd_in_t;

  typedef struct packed {
    logic signed [QW-1:0] prod_real;
    logic signed [QW-1:0] prod_imag;
    logic signed [QW-1:0] quot_real;
    logic signed [QW-1:0] quot_imag;
    logic                 divide_by_zero;
    logic                 saturated;
  } cpmd_out_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [AW-1:0]        ang;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    logic dz;
  } polar_t;

  typedef struct packed {
    logic [61:0] hi_p;
    logic [57:0] lo_p;
  } dgp_t;

  typedef struct packed {
    dgp_t          ga;
    dgp_t          gb;
    logic [AW-1:0] ang_a;
    logic [AW-1:0] ang_b;
    logic          dz;
  } gain1_t;

  typedef struct packed {
    logic [MW-1:0] ma;
    logic [MW-1:0] mb;
    logic [AW-1:0] ang_a;
    logic [AW-1:0] ang_b;
    logic          dz;
  } gain2_t;

  typedef struct packed {
    logic [MW-1:0]  rem;
    logic [DW-1:0]  quo;
    logic [DW-1:0]  num;
    logic [MW-1:0]  dvs;
    logic [PMW-1:0] pm;
    logic [AW-1:0]  psum;
    logic [AW-1:0]  pdiff;
    logic           dz;
  } div_t;

  typedef struct packed {
    dgp_t          gp;
    dgp_t          gq;
    logic [AW-1:0] psum;
    logic [AW-1:0] pdiff;
    logic          dz;
  } gain3_t;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } rot_t;

  typedef struct packed {
    rot_t p;
    rot_t q;
    logic dz;
  } rpair_t;

  typedef struct packed {
    logic          sat;
    logic [QW-1:0] val;
  } q16_t;

  function automatic vec_t vec_prep(logic signed [IN_WIDTH-1:0] re,
                                    logic signed [IN_WIDTH-1:0] im);
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    vec_t r;
    x = XW'(re) <<< IN_SHIFT;
    y = XW'(im) <<< IN_SHIFT;
    r.zero = (x == '0) && (y == '0);
    if (x[XW-1]) begin
      r.x   = -x;
      r.y   = -y;
      r.ang = HALF_TURN;
    end else begin
      r.x   = x;
      r.y   = y;
      r.ang = '0;
    end
    return r;
  endfunction

  function automatic vec_t vec_step(vec_t s, int unsigned i);
    vec_t r;
    r = s;
    if (!s.y[XW-1]) begin
      r.x   = s.x + (s.y >>> i);
      r.y   = s.y - (s.x >>> i);
      r.ang = s.ang + ATAN_TURNS[i[4:0]];
    end else begin
      r.x   = s.x - (s.y >>> i);
      r.y   = s.y + (s.x >>> i);
      r.ang = s.ang - ATAN_TURNS[i[4:0]];
    end
    return r;
  endfunction

  function automatic dgp_t dg_mul(logic [DGW-1:0] m);
    dgp_t r;
    r.hi_p = 62'(m[DGW-1:28]) * 62'(INV_GAIN);
    r.lo_p = 58'(m[27:0]) * 58'(INV_GAIN);
    return r;
  endfunction

  function automatic logic [DGW-1:0] dg_fin(dgp_t p);
    logic [58:0] t;
    t = 59'({p.hi_p[1:0], 28'b0}) + 59'(p.lo_p);
    return DGW'(p.hi_p >> 2) + DGW'(t >> 30);
  endfunction

  function automatic div_t div_step(div_t s);
    logic [MW:0] t;
    div_t r;
    r     = s;
    t     = {s.rem, s.num[DW-1]};
    r.num = s.num << 1;
    if (t >= {1'b0, s.dvs}) begin
      r.rem = MW'(t - {1'b0, s.dvs});
      r.quo = {s.quo[DW-2:0], 1'b1};
    end else begin
      r.rem = t[MW-1:0];
      r.quo = {s.quo[DW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic rot_t rot_prep(logic [DGW-1:0] m, logic [AW-1:0] ang);
    logic [AW-1:0] t;
    logic [AW-1:0] a2;
    rot_t r;
    t      = ang + QUARTER_TURN;
    r.flip = t[AW-1];
    a2     = r.flip ? ang - HALF_TURN : ang;
    r.z    = ZW'($signed(a2));
    r.x    = $signed(RW'(m));
    r.y    = '0;
    return r;
  endfunction

  function automatic rot_t rot_step(rot_t s, int unsigned i);
    rot_t r;
    r = s;
    if (!s.z[ZW-1]) begin
      r.x = s.x - (s.y >>> i);
      r.y = s.y + (s.x >>> i);
      r.z = s.z - $signed(ZW'(ATAN_TURNS[i[4:0]]));
    end else begin
      r.x = s.x + (s.y >>> i);
      r.y = s.y - (s.x >>> i);
      r.z = s.z + $signed(ZW'(ATAN_TURNS[i[4:0]]));
    end
    return r;
  endfunction

  function automatic q16_t to_q16(logic signed [RW-1:0] c, logic flip);
    logic signed [RW:0] cc;
    logic signed [RW:0] v;
    q16_t r;
    cc = flip ? -(RW+1)'(c) : (RW+1)'(c);
    v  = (cc + (RW+1)'(128)) >>> 8;
    if (v > Q_MAX) begin
      r.sat = 1'b1;
      r.val = QW'(Q_MAX);
    end else if (v < Q_MIN) begin
      r.sat = 1'b1;
      r.val = QW'(Q_MIN);
    end else begin
      r.sat = 1'b0;
      r.val = QW'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/complex_polar_mul_div_core.sv =====
// ----------------------------------------------------------------------------
// complex_polar_mul_div_core
// Product and quotient of two complex numbers through polar form.
// ----------------------------------------------------------------------------
// A new operand pair is taken in every cycle while in_stall is low, and results
// leave in order. The depth is set by the two CORDIC chains (vectoring and
// rotation, one step per stage) and the 57-stage restoring divider for the
// quotient modulus. The whole pipeline holds while a result waits under
// out_stall, so no transfer is lost.
`default_nettype none

module complex_polar_mul_div_core import cpmd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cpmd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cpmd_out_t out_data
);

  localparam int unsigned LAT = 2 * CORDIC_STEPS + DW + 7;

  logic           adv;
  logic [LAT-1:0] vld_r;

  polar_t    pol_r [0:CORDIC_STEPS];
  gain1_t    g1_r;
  gain2_t    g2_r;
  div_t      div_r [0:DW];
  gain3_t    g3_r;
  rpair_t    rot_r [0:CORDIC_STEPS];
  cpmd_out_t out_r;

  logic [DGW-1:0] mod_a;
  logic [DGW-1:0] mod_b;
  logic [MW-1:0]  ma;
  logic [MW-1:0]  mb;
  q16_t           pr;
  q16_t           pi;
  q16_t           qr;
  q16_t           qi;

  assign adv       = !vld_r[LAT-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pol_r[0].a  <= vec_prep(in_data.a_real, in_data.a_imag);
      pol_r[0].b  <= vec_prep(in_data.b_real, in_data.b_imag);
      pol_r[0].dz <= (in_data.b_real == '0) && (in_data.b_imag == '0);
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    always_ff @(posedge clk) begin
      if (adv) begin
        pol_r[k+1].a  <= vec_step(pol_r[k].a, k);
        pol_r[k+1].b  <= vec_step(pol_r[k].b, k);
        pol_r[k+1].dz <= pol_r[k].dz;
      end
    end
  end

  always_comb begin
    mod_a = '0;
    mod_b = '0;
    if (!pol_r[CORDIC_STEPS].a.zero && !pol_r[CORDIC_STEPS].a.x[XW-1]) begin
      mod_a = DGW'($unsigned(pol_r[CORDIC_STEPS].a.x));
    end
    if (!pol_r[CORDIC_STEPS].b.zero && !pol_r[CORDIC_STEPS].b.x[XW-1]) begin
      mod_b = DGW'($unsigned(pol_r[CORDIC_STEPS].b.x));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_r.ga    <= dg_mul(mod_a);
      g1_r.gb    <= dg_mul(mod_b);
      g1_r.ang_a <= pol_r[CORDIC_STEPS].a.zero ? '0 : pol_r[CORDIC_STEPS].a.ang;
      g1_r.ang_b <= pol_r[CORDIC_STEPS].b.zero ? '0 : pol_r[CORDIC_STEPS].b.ang;
      g1_r.dz    <= pol_r[CORDIC_STEPS].dz;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g2_r.ma    <= MW'(dg_fin(g1_r.ga));
      g2_r.mb    <= MW'(dg_fin(g1_r.gb));
      g2_r.ang_a <= g1_r.ang_a;
      g2_r.ang_b <= g1_r.ang_b;
      g2_r.dz    <= g1_r.dz;
    end
  end

  assign ma = g2_r.ma;
  assign mb = g2_r.mb;

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0].rem   <= '0;
      div_r[0].quo   <= '0;
      div_r[0].num   <= {ma, 24'b0};
      div_r[0].dvs   <= (mb == '0) ? MW'(1) : mb;
      div_r[0].pm    <= PMW'(((2*MW)'(ma) * (2*MW)'(mb)) >> 32);
      div_r[0].psum  <= g2_r.ang_a + g2_r.ang_b;
      div_r[0].pdiff <= g2_r.ang_a - g2_r.ang_b;
      div_r[0].dz    <= g2_r.dz;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[k+1] <= div_step(div_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g3_r.gp    <= dg_mul(DGW'(div_r[DW].pm));
      g3_r.gq    <= dg_mul(DGW'(div_r[DW].quo));
      g3_r.psum  <= div_r[DW].psum;
      g3_r.pdiff <= div_r[DW].pdiff;
      g3_r.dz    <= div_r[DW].dz;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_r[0].p  <= rot_prep(dg_fin(g3_r.gp), g3_r.psum);
      rot_r[0].q  <= rot_prep(dg_fin(g3_r.gq), g3_r.pdiff);
      rot_r[0].dz <= g3_r.dz;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    always_ff @(posedge clk) begin
      if (adv) begin
        rot_r[k+1].p  <= rot_step(rot_r[k].p, k);
        rot_r[k+1].q  <= rot_step(rot_r[k].q, k);
        rot_r[k+1].dz <= rot_r[k].dz;
      end
    end
  end

  always_comb begin
    pr = to_q16(rot_r[CORDIC_STEPS].p.x, rot_r[CORDIC_STEPS].p.flip);
    pi = to_q16(rot_r[CORDIC_STEPS].p.y, rot_r[CORDIC_STEPS].p.flip);
    qr = to_q16(rot_r[CORDIC_STEPS].q.x, rot_r[CORDIC_STEPS].q.flip);
    qi = to_q16(rot_r[CORDIC_STEPS].q.y, rot_r[CORDIC_STEPS].q.flip);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.prod_real      <= pr.val;
      out_r.prod_imag      <= pi.val;
      out_r.quot_real      <= rot_r[CORDIC_STEPS].dz ? '0 : qr.val;
      out_r.quot_imag      <= rot_r[CORDIC_STEPS].dz ? '0 : qi.val;
      out_r.divide_by_zero <= rot_r[CORDIC_STEPS].dz;
      out_r.saturated      <= pr.sat || pi.sat ||
                              (!rot_r[CORDIC_STEPS].dz && (qr.sat || qi.sat));
    end
  end

endmodule

`default_nettype wire
